/* hdl/fdot_pkg.sv */
// shared types and constants for the fp8 e4m3 block scaled dot unit
// no dependencies
`timescale 1ns / 1ps
package fdot_pkg;

  localparam int unsigned LANES = 4;

  // configuration register indexes
  localparam logic CFG_BLOCK_LENGTH = 1'b0;
  localparam logic CFG_ACTIVE_ROWS  = 1'b1;

  localparam logic [15:0] BLOCK_LENGTH_RST = 16'd32;
  localparam logic [2:0]  ACTIVE_ROWS_RST  = 3'd1;

  localparam logic [31:0] FP32_QNAN = 32'h7fc0_0000;
  localparam logic [7:0]  E4M3_EXP_ADJ = 8'd120;

  typedef struct packed {
    logic [31:0] activation;
    logic [7:0]  weight_row0;
    logic [7:0]  weight_row1;
    logic [7:0]  weight_row2;
    logic [7:0]  weight_row3;
    logic [31:0] block_scale;
    logic        last_element;
  } in_t;

  typedef struct packed {
    logic [31:0] row0_total;
    logic [31:0] row1_total;
    logic [31:0] row2_total;
    logic [31:0] row3_total;
  } out_t;

  // one classified beat handed from front to back
  typedef struct packed {
    logic [31:0]            activation;
    logic [LANES-1:0][31:0] weight;
    logic [31:0]            block_scale;
    logic                   close;
    logic                   last;
    logic [1:0]             row_last;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ADD,
    B_SMUL,
    B_SADD,
    B_EMIT
  } back_state_e;

endpackage

/* hdl/fdot_front.sv */
// front end: accepts beats, decodes e4m3 weights, tracks block position
// depends on fdot_pkg
`timescale 1ns / 1ps
module fdot_front #(
  parameter int unsigned ROWS = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  fdot_pkg::in_t  in_data_i,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output fdot_pkg::entry_t q_data_o
);
  import fdot_pkg::*;

  localparam logic [2:0] RowsMax = 3'(ROWS);

  logic [15:0] block_length_q;
  logic [2:0]  active_rows_q;
  logic [15:0] pos_q, pos_d;
  logic [15:0] pos_next;
  logic        close;
  logic [2:0]  rows_use;
  logic        accept;

  // e4m3 byte to fp32 bits
  function automatic logic [31:0] e4m3_to_fp32(logic [7:0] b);
    logic       s;
    logic [3:0] e;
    logic [2:0] m;
    logic [31:0] r;
    s = b[7];
    e = b[6:3];
    m = b[2:0];
    if (e == 4'hf && m == 3'h7) begin
      r = {s, FP32_QNAN[30:0]};
    end else if (e == 4'h0) begin
      if (m[2]) begin
        r = {s, 8'd120, m[1:0], 21'd0};
      end else if (m[1]) begin
        r = {s, 8'd119, m[0], 22'd0};
      end else if (m[0]) begin
        r = {s, 8'd118, 23'd0};
      end else begin
        r = {s, 31'd0};
      end
    end else begin
      r = {s, {4'd0, e} + E4M3_EXP_ADJ, m, 20'd0};
    end
    return r;
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  // row count clamp
  always_comb begin
    rows_use = active_rows_q;
    if (rows_use == 3'd0) begin
      rows_use = 3'd1;
    end
    if (rows_use > RowsMax) begin
      rows_use = RowsMax;
    end
  end

  // block position and close decision
  assign pos_next = pos_q + 16'd1;
  assign close    = in_data_i.last_element || (pos_next == block_length_q);

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = close ? 16'd0 : pos_next;
    end
  end

  // classified beat
  always_comb begin
    q_data_o.activation  = in_data_i.activation;
    q_data_o.weight[0]   = e4m3_to_fp32(in_data_i.weight_row0);
    q_data_o.weight[1]   = e4m3_to_fp32(in_data_i.weight_row1);
    q_data_o.weight[2]   = e4m3_to_fp32(in_data_i.weight_row2);
    q_data_o.weight[3]   = e4m3_to_fp32(in_data_i.weight_row3);
    q_data_o.block_scale = in_data_i.block_scale;
    q_data_o.close       = close;
    q_data_o.last        = in_data_i.last_element;
    q_data_o.row_last    = 2'(rows_use - 3'd1);
  end

  // config and position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q <= BLOCK_LENGTH_RST;
      active_rows_q  <= ACTIVE_ROWS_RST;
      pos_q          <= 16'd0;
    end else begin
      pos_q <= pos_d;
      if (cfg_we_i && cfg_idx_i == CFG_BLOCK_LENGTH) begin
        block_length_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_ACTIVE_ROWS) begin
        active_rows_q <= cfg_wdata_i[2:0];
      end
    end
  end

endmodule

/* hdl/fdot_fifo.sv */
// two-entry queue between front and back
// depends on fdot_pkg
`timescale 1ns / 1ps
module fdot_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fdot_pkg::entry_t data_i,
  input  logic             pop_i,
  output fdot_pkg::entry_t data_o,
  output logic             full_o,
  output logic             empty_o
);
  import fdot_pkg::*;

  entry_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

/* hdl/fdot_back.sv */
// back end: shared fp32 multiplier and adder stepping through rows
// depends on fdot_pkg
`timescale 1ns / 1ps
module fdot_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  fdot_pkg::entry_t q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fdot_pkg::out_t   out_data_o
);
  import fdot_pkg::*;

  back_state_e            state_q, state_d;
  entry_t                 ent_q;
  logic [1:0]             row_q, row_d;
  logic [31:0]            prod_q;
  logic [LANES-1:0][31:0] part_q;
  logic [LANES-1:0][31:0] tot_q;
  out_t                   out_q;
  logic                   out_valid_q;
  logic [31:0]            mul_a, mul_b, mul_r;
  logic [31:0]            add_a, add_r;
  logic                   row_end;
  logic                   load, take_prod, upd_part, upd_tot, clr_part, emit;

  // fp32 multiply, round to nearest even
  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    logic [7:0]  ea, eb, ef;
    logic [22:0] fa, fb, frac;
    logic        sr, an, bn, ai, bi, az, bz, g, st, inc, lost;
    logic [47:0] p, pn, ps, mask;
    logic [5:0]  lz, sh;
    logic signed [10:0] e;
    logic [31:0] pk;
    ea = a[30:23]; eb = b[30:23]; fa = a[22:0]; fb = b[22:0];
    sr = a[31] ^ b[31];
    an = ea == 8'hff && fa != 23'd0; bn = eb == 8'hff && fb != 23'd0;
    ai = ea == 8'hff && fa == 23'd0; bi = eb == 8'hff && fb == 23'd0;
    az = ea == 8'h00 && fa == 23'd0; bz = eb == 8'h00 && fb == 23'd0;
    if (an || bn || (ai && bz) || (bi && az)) begin
      return FP32_QNAN;
    end
    if (ai || bi) begin
      return {sr, 8'hff, 23'd0};
    end
    if (az || bz) begin
      return {sr, 31'd0};
    end
    p  = {ea != 8'd0, fa} * {eb != 8'd0, fb};
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) begin
        lz = 6'(47 - i);
      end
    end
    pn = p << lz;
    e  = $signed({3'd0, (ea == 8'd0) ? 8'd1 : ea})
       + $signed({3'd0, (eb == 8'd0) ? 8'd1 : eb})
       - 11'sd126 - $signed({5'd0, lz});
    if (e >= 11'sd255) begin
      return {sr, 8'hff, 23'd0};
    end
    if (e <= 11'sd0) begin
      sh   = (e < -11'sd47) ? 6'd48 : 6'(11'sd1 - e);
      ps   = pn >> sh;
      mask = (48'd1 << sh) - 48'd1;
      lost = |(pn & mask);
      ef   = 8'd0;
    end else begin
      ps   = pn;
      lost = 1'b0;
      ef   = e[7:0];
    end
    frac = ps[46:24];
    g    = ps[23];
    st   = (|ps[22:0]) | lost;
    inc  = g & (st | frac[0]);
    pk   = {1'b0, ef, frac} + {31'd0, inc};
    pk[31] = sr;
    return pk;
  endfunction

  // fp32 add, round to nearest even
  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    logic [31:0] x, y, pk;
    logic [7:0]  ex, ey, d;
    logic [8:0]  en;
    logic [26:0] mx, my, mys, mask, n;
    logic [27:0] sum;
    logic [4:0]  lz, s, lim;
    logic        an, bn, ai, bi, g, st, inc;
    an = a[30:23] == 8'hff && a[22:0] != 23'd0;
    bn = b[30:23] == 8'hff && b[22:0] != 23'd0;
    ai = a[30:23] == 8'hff && a[22:0] == 23'd0;
    bi = b[30:23] == 8'hff && b[22:0] == 23'd0;
    if (an || bn || (ai && bi && a[31] != b[31])) begin
      return FP32_QNAN;
    end
    if (ai) begin
      return a;
    end
    if (bi) begin
      return b;
    end
    if (a[30:0] < b[30:0]) begin
      x = b; y = a;
    end else begin
      x = a; y = b;
    end
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {x[30:23] != 8'd0, x[22:0], 3'd0};
    my = {y[30:23] != 8'd0, y[22:0], 3'd0};
    d  = ex - ey;
    if (d >= 8'd27) begin
      mys = {26'd0, |my};
    end else begin
      mask = (27'd1 << d[4:0]) - 27'd1;
      mys  = (my >> d[4:0]) | {26'd0, |(my & mask)};
    end
    if (x[31] ^ y[31]) begin
      sum = {1'b0, mx} - {1'b0, mys};
    end else begin
      sum = {1'b0, mx} + {1'b0, mys};
    end
    if (sum == 28'd0) begin
      return {x[31] & y[31], 31'd0};
    end
    if (sum[27]) begin
      n  = {sum[27:2], sum[1] | sum[0]};
      en = {1'b0, ex} + 9'd1;
    end else begin
      lz = 5'd0;
      for (int i = 0; i < 27; i++) begin
        if (sum[i]) begin
          lz = 5'(26 - i);
        end
      end
      lim = (ex - 8'd1 > 8'd26) ? 5'd26 : 5'(ex - 8'd1);
      s   = (lz < lim) ? lz : lim;
      n   = sum[26:0] << s;
      en  = n[26] ? ({1'b0, ex} - {4'd0, s}) : 9'd0;
    end
    if (en >= 9'd255) begin
      return {x[31], 8'hff, 23'd0};
    end
    g   = n[2];
    st  = |n[1:0];
    inc = g & (st | n[3]);
    pk  = {1'b0, en[7:0], n[25:3]} + {31'd0, inc};
    pk[31] = x[31];
    return pk;
  endfunction

  function automatic logic [31:0] canon(logic [31:0] v);
    return (v[30:23] == 8'hff && v[22:0] != 23'd0) ? FP32_QNAN : v;
  endfunction

  // shared arithmetic operand selection
  assign mul_a   = (state_q == B_MUL) ? ent_q.weight[row_q] : part_q[row_q];
  assign mul_b   = (state_q == B_MUL) ? ent_q.activation : ent_q.block_scale;
  assign mul_r   = fmul(mul_a, mul_b);
  assign add_a   = (state_q == B_ADD) ? part_q[row_q] : tot_q[row_q];
  assign add_r   = fadd(add_a, prod_q);
  assign row_end = row_q == ent_q.row_last;

  // sequencer
  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    load      = 1'b0;
    take_prod = 1'b0;
    upd_part  = 1'b0;
    upd_tot   = 1'b0;
    clr_part  = 1'b0;
    emit      = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          load    = 1'b1;
          row_d   = 2'd0;
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        take_prod = 1'b1;
        state_d   = B_ADD;
      end
      B_ADD: begin
        upd_part = 1'b1;
        if (!row_end) begin
          row_d   = row_q + 2'd1;
          state_d = B_MUL;
        end else if (ent_q.close) begin
          row_d   = 2'd0;
          state_d = B_SMUL;
        end else begin
          state_d = B_IDLE;
        end
      end
      B_SMUL: begin
        take_prod = 1'b1;
        state_d   = B_SADD;
      end
      B_SADD: begin
        upd_tot = 1'b1;
        if (!row_end) begin
          row_d   = row_q + 2'd1;
          state_d = B_SMUL;
        end else begin
          clr_part = 1'b1;
          state_d  = ent_q.last ? B_EMIT : B_IDLE;
        end
      end
      B_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          emit    = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      row_q       <= 2'd0;
      part_q      <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      if (upd_part) begin
        part_q[row_q] <= add_r;
      end
      if (upd_tot) begin
        tot_q[row_q] <= add_r;
      end
      if (clr_part) begin
        part_q <= '0;
      end
      if (emit) begin
        tot_q <= '0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= q_data_i;
    end
    if (take_prod) begin
      prod_q <= mul_r;
    end
    if (emit) begin
      out_q.row0_total <= canon(tot_q[0]);
      out_q.row1_total <= (ent_q.row_last >= 2'd1) ? canon(tot_q[1]) : 32'd0;
      out_q.row2_total <= (ent_q.row_last >= 2'd2) ? canon(tot_q[2]) : 32'd0;
      out_q.row3_total <= (ent_q.row_last == 2'd3) ? canon(tot_q[3]) : 32'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/fp8_e4m3_block_scaled_dot_unit.sv */
// top level of the fp8 e4m3 block scaled dot unit
// depends on fdot_pkg, fdot_front, fdot_fifo, fdot_back
`timescale 1ns / 1ps
// usage
// - input channel in_valid_i / in_stall_o / in_data_i: one beat is one fp32
//   activation, four e4m3 weight bytes, the block scale and a last flag
// - output channel out_valid_o / out_stall_i / out_data_o: one beat of four
//   fp32 row totals after each beat flagged last
// - cfg_we_i / cfg_idx_i / cfg_wdata_i write block_length (0) and active_rows (1)
// - the front decodes a beat in the cycle it is taken and pushes it into a
//   two-entry queue; the back pops it and runs one shared fp32 multiplier
//   and one shared fp32 adder over the active rows, one row at a time
// - per beat the back multiplies and accumulates each active row; when the
//   beat closes a block it scales each row partial by the block scale and
//   adds it to the row total, and after a last beat it hands off the result;
//   it pops no new beat until it is through with the current one
// - reset clears the position, all partials and totals, block_length to 32
//   and active_rows to 1
// - a stalled result is held in the output register; the back keeps
//   working on later beats and only waits when it has a new result to hand
//   over; the input stalls while the queue is full
module fp8_e4m3_block_scaled_dot_unit #(
  parameter int unsigned ROWS = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  fdot_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fdot_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i
);
  import fdot_pkg::*;

  entry_t push_data, pop_data;
  logic   q_push, q_pop, q_full, q_empty;

  fdot_front #(
    .ROWS(ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (push_data)
  );

  fdot_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (push_data),
    .pop_i  (q_pop),
    .data_o (pop_data),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  fdot_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (pop_data),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("pop from empty queue");

  // emitted nan totals on row 0 are canonical
  a_nan_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.row0_total[30:23] == 8'hff &&
    out_data_o.row0_total[22:0] != 23'd0 |-> out_data_o.row0_total == FP32_QNAN)
    else $error("non-canonical nan on row 0");

endmodule

/* tb/tb_fp8_e4m3_block_scaled_dot_unit.sv */
// self-checking testbench for the fp8 e4m3 block scaled dot unit
// depends on fdot_pkg and fp8_e4m3_block_scaled_dot_unit; bit-exact fp32 predictor inside
`timescale 1ns / 1ps
module tb_fp8_e4m3_block_scaled_dot_unit;
  import fdot_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_idx = CFG_BLOCK_LENGTH;
  logic [15:0] cfg_wdata = '0;

  fp8_e4m3_block_scaled_dot_unit #(.ROWS(4)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // fp32 arithmetic done in double and rounded once: exact for mul and add
  function automatic real fp32_to_real(logic [31:0] b);
    real v;
    if (b[30:23] == 8'hff) begin
      if (b[22:0] != 0) return $bitstoreal(64'h7ff8_0000_0000_0000);
      return $bitstoreal({b[31], 11'h7ff, 52'd0});
    end
    if (b[30:23] == 8'h00) begin
      if (b[22:0] == 0) return $bitstoreal({b[31], 63'd0});
      v = real'(b[22:0]) * (2.0 ** -149);
      return b[31] ? -v : v;
    end
    return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0});
  endfunction

  function automatic logic [31:0] real_to_fp32(real x);
    logic [63:0] b;
    logic [63:0] sig, q, rem, half;
    int ex, sh;
    b = $realtobits(x);
    if (b[62:52] == 11'h7ff) return (b[51:0] != 0) ? FP32_QNAN : {b[63], 8'hff, 23'd0};
    if (b[62:52] == 11'h000) return {b[63], 31'd0};
    sig = {11'd0, 1'b1, b[51:0]};
    ex = int'(b[62:52]) - 1023 + 127;
    sh = (ex >= 1) ? 29 : 30 - ex;
    if (sh > 60) sh = 60;
    q = sig >> sh;
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    // round to nearest, ties to even
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (ex < 1) return {b[63], q[30:0]};
    if (q[24]) begin
      q = q >> 1;
      ex++;
    end
    if (ex >= 255) return {b[63], 8'hff, 23'd0};
    return {b[63], 8'(ex), q[22:0]};
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    return real_to_fp32(fp32_to_real(a) * fp32_to_real(b));
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    return real_to_fp32(fp32_to_real(a) + fp32_to_real(b));
  endfunction

  function automatic logic [31:0] e4m3_to_fp32(logic [7:0] w);
    if (w[6:0] == 7'h7f) return {w[7], FP32_QNAN[30:0]};
    if (w[6:3] == 4'd0) return real_to_fp32(real'(w[2:0]) / 512.0) ^ {w[7], 31'd0};
    return {w[7], 8'(w[6:3] + E4M3_EXP_ADJ), w[2:0], 20'd0};
  endfunction

  function automatic logic [31:0] canon(logic [31:0] f);
    return (f[30:23] == 8'hff && f[22:0] != 0) ? FP32_QNAN : f;
  endfunction

  // predictor state, mirrored registers
  logic [15:0] len_q = BLOCK_LENGTH_RST;
  logic [2:0] rows_q = ACTIVE_ROWS_RST;
  logic [15:0] pos_q = '0;
  logic [31:0] partial_q [4] = '{default: '0};
  logic [31:0] total_q [4] = '{default: '0};

  task automatic dot_step(input in_t d, output bit has, output out_t o);
    logic [7:0] w [4];
    logic [31:0] tot [4];
    logic [15:0] nxt;
    int n;
    bit close;
    w = '{d.weight_row0, d.weight_row1, d.weight_row2, d.weight_row3};
    n = (rows_q == 0) ? 1 : (rows_q > 4 ? 4 : int'(rows_q));
    nxt = pos_q + 16'd1;
    close = d.last_element || nxt == len_q;
    for (int r = 0; r < n; r++)
      partial_q[r] = fadd(partial_q[r], fmul(e4m3_to_fp32(w[r]), d.activation));
    if (close) begin
      for (int r = 0; r < n; r++)
        total_q[r] = fadd(total_q[r], fmul(partial_q[r], d.block_scale));
      partial_q = '{default: '0};
      pos_q = '0;
    end else begin
      pos_q = nxt;
    end
    has = d.last_element;
    for (int r = 0; r < 4; r++) tot[r] = (r < n) ? canon(total_q[r]) : '0;
    o = '{tot[0], tot[1], tot[2], tot[3]};
    if (has) begin
      total_q = '{default: '0};
      pos_q = '0;
    end
  endtask

  out_t totals_pending [$];
  int fails = 0;
  int beats_in = 0;
  int beats_out = 0;
  int cycles = 0;
  bit typed_on = 1'b0;
  out_t typed_val;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  // input side: predict each accepted beat
  always @(posedge clk) begin
    bit has;
    out_t o;
    if (rst_n && in_valid && !in_stall) begin
      beats_in++;
      dot_step(in_data, has, o);
      if (has) totals_pending.push_back(typed_on ? typed_val : o);
    end
  end

  // output side: compare against oldest expectation
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      if (totals_pending.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        fails++;
      end else begin
        e = totals_pending.pop_front();
        if (out_data.row0_total !== e.row0_total) begin
          $error("row0_total exp %h got %h", e.row0_total, out_data.row0_total); fails++;
        end
        if (out_data.row1_total !== e.row1_total) begin
          $error("row1_total exp %h got %h", e.row1_total, out_data.row1_total); fails++;
        end
        if (out_data.row2_total !== e.row2_total) begin
          $error("row2_total exp %h got %h", e.row2_total, out_data.row2_total); fails++;
        end
        if (out_data.row3_total !== e.row3_total) begin
          $error("row3_total exp %h got %h", e.row3_total, out_data.row3_total); fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_fp8_e4m3_block_scaled_dot_unit: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, optional long hold
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      g = quiet ? 0 : $urandom_range(0, 9);
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && !hold_req);
    end
  end

  task automatic send_beat(input in_t d);
    int g;
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
    g = quiet ? 0 : $urandom_range(0, 9);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (totals_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BLOCK_LENGTH) len_q = v;
    else rows_q = v[2:0];
  endtask

  function automatic logic [31:0] rand_fp32(bit scale);
    logic [31:0] specials [8] = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000,
      32'hff80_0000, 32'h7fc0_0001, 32'h0000_0001, 32'h7f7f_ffff, 32'h8080_0000};
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return specials[$urandom_range(0, 7)];
    if (k == 1) return $urandom();
    // moderate magnitudes keep sums meaningful
    return {1'($urandom), 8'($urandom_range(scale ? 120 : 110, scale ? 134 : 144)),
            23'($urandom)};
  endfunction

  function automatic in_t rand_beat(int last_odds);
    in_t d;
    d.activation = rand_fp32(1'b0);
    d.weight_row0 = 8'($urandom);
    d.weight_row1 = 8'($urandom);
    d.weight_row2 = 8'($urandom);
    d.weight_row3 = 8'($urandom);
    d.block_scale = rand_fp32(1'b1);
    d.last_element = ($urandom_range(1, last_odds) == 1);
    return d;
  endfunction

  typedef struct {
    logic [31:0] act;
    logic [7:0] w0;
    logic [31:0] scale;
    bit lst;
    bit typed;
    logic [31:0] t0;
  } dir_row_t;

  // rows 1..3 inactive here, so typed totals have only row 0
  dir_row_t dir_tab [14] = '{
    '{32'h3f80_0000, 8'h38, 32'h3f80_0000, 1, 1, 32'h3f80_0000},
    '{32'h3f80_0000, 8'h7f, 32'h3f80_0000, 1, 1, FP32_QNAN},
    '{32'h3f80_0000, 8'hff, 32'h3f80_0000, 1, 1, FP32_QNAN},
    '{32'hffc0_0001, 8'h38, 32'h3f80_0000, 1, 1, FP32_QNAN},
    '{32'h7f80_0000, 8'h00, 32'h3f80_0000, 1, 1, FP32_QNAN},
    '{32'h3f80_0000, 8'h00, 32'h3f80_0000, 1, 1, 32'h0000_0000},
    '{32'h7f7f_ffff, 8'h01, 32'h3f80_0000, 0, 0, 32'h0},
    '{32'h0000_0001, 8'h87, 32'h7f7f_ffff, 0, 0, 32'h0},
    '{32'h4000_0000, 8'h7e, 32'h3f00_0000, 0, 0, 32'h0},
    '{32'hc000_0000, 8'hfe, 32'h4000_0000, 1, 0, 32'h0},
    '{32'hff80_0000, 8'h40, 32'h0000_0000, 1, 0, 32'h0},
    '{32'h7f7f_ffff, 8'h7e, 32'h7f7f_ffff, 1, 0, 32'h0},
    '{32'h8000_0000, 8'h80, 32'hbf80_0000, 1, 0, 32'h0},
    '{32'hffff_ffff, 8'hff, 32'hffff_ffff, 1, 0, 32'h0}
  };

  // block_length, active_rows per random phase
  logic [15:0] ph_len [10] = '{16'd1, 16'd3, 16'd0, 16'd65535, 16'd5,
                               16'd2, 16'd4, 16'd7, 16'd1, 16'd3};
  logic [15:0] ph_rows [10] = '{16'd4, 16'd2, 16'd4, 16'd3, 16'd0,
                                16'd7, 16'd5, 16'd4, 16'd1, 16'd4};

  initial begin
    in_t d;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats at reset settings
    // typed expectation switches after the edge so the previous beat keeps its own
    foreach (dir_tab[i]) begin
      d = '{dir_tab[i].act, dir_tab[i].w0, 8'($urandom), 8'($urandom), 8'($urandom),
            dir_tab[i].scale, dir_tab[i].lst};
      typed_on <= dir_tab[i].typed;
      typed_val <= '{dir_tab[i].t0, 32'h0, 32'h0, 32'h0};
      send_beat(d);
    end
    typed_on <= 1'b0;
    drain();

    // random phases across register settings
    foreach (ph_len[p]) begin
      write_reg(CFG_BLOCK_LENGTH, ph_len[p]);
      write_reg(CFG_ACTIVE_ROWS, ph_rows[p]);
      quiet = (p == 4);
      if (p == 2) begin
        // long receiver hold while beats keep coming
        hold_req = 1'b1;
        repeat (30) send_beat(rand_beat(3));
      end
      repeat (105) send_beat(rand_beat((p % 3 == 0) ? 4 : 20));
      // sender waits out every pending result
      drain();
    end
    quiet = 1'b0;

    $display("beats in %0d, result beats %0d, over %0d register settings",
             beats_in, beats_out, $size(ph_len) + 1);
    if (fails == 0 && totals_pending.size() == 0) begin
      $display("tb_fp8_e4m3_block_scaled_dot_unit: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", fails, totals_pending.size());
      $display("tb_fp8_e4m3_block_scaled_dot_unit: FAIL");
    end
    $finish;
  end

endmodule
